FILE: src/cnsf_pkg.sv
// Shared constants, register codes and controller/datapath interface types.
package cnsf_pkg;

  localparam int MAX_POINTS    = 64;
  localparam int FRACTION_BITS = 4;
  localparam int COORD_W       = 16;
  localparam int IDX_W         = $clog2(MAX_POINTS);
  localparam int CNT_W         = $clog2(MAX_POINTS + 1);
  localparam int NBR_W         = 6;
  localparam int CFG_IDX_W     = 2;
  localparam int SQ_W          = 2 * COORD_W;

  localparam logic [COORD_W-1:0] DIST_RESET   = COORD_W'(180 << FRACTION_BITS);
  localparam logic [NBR_W-1:0]   NBR_RESET    = NBR_W'(3);
  localparam logic [COORD_W-1:0] SPREAD_RESET = COORD_W'(50 << FRACTION_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIST     = 2'd0,
    CFG_MIN_NBR  = 2'd1,
    CFG_SPREAD_X = 2'd2,
    CFG_SPREAD_Y = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             load_we;
    logic [IDX_W-1:0] load_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             scan_valid;
    logic             th_load;
    logic             latch_outer;
    logic             push_pending;
    logic             set_pending;
    logic             finish;
  } cnsf_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
    logic kept;
    logic pending_valid;
  } cnsf_stat_t;

endpackage

FILE: src/cnsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cnsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/cnsf_ctrl.sv
// Controller state machine: point loading, outer/inner scan sequencing, result release.
module cnsf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                final_point,
  input  cnsf_pkg::cnsf_stat_t stat,
  output cnsf_pkg::cnsf_cmd_t  cmd
);
  import cnsf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_FETCH,
    S_LATCH,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] outer;
  logic [IDX_W-1:0] inner;
  logic             room;
  logic             advance;
  logic             last_outer;
  logic             last_inner;

  assign room       = count < CNT_W'(MAX_POINTS);
  assign advance    = !stat.kept || !stat.pending_valid || stat.out_free;
  assign last_outer = CNT_W'(outer) == count - CNT_W'(1);
  assign last_inner = CNT_W'(inner) == count - CNT_W'(1);
  assign in_stall   = state != S_IDLE;

  always_comb begin
    cmd            = '0;
    cmd.load_addr  = count[IDX_W-1:0];
    cmd.rd_addr    = (state == S_SCAN) ? inner : outer;
    case (state)
      S_IDLE:   cmd.load_we = in_valid && room;
      S_START:  cmd.th_load = 1'b1;
      S_LATCH:  cmd.latch_outer = 1'b1;
      S_SCAN:   cmd.scan_valid = inner != outer;
      S_DECIDE: begin
        cmd.set_pending  = stat.kept && advance;
        cmd.push_pending = stat.kept && stat.pending_valid && advance;
      end
      S_FINISH: cmd.finish = stat.out_free;
      default:  cmd.rd_addr = outer;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      outer <= '0;
      inner <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (room) begin
              count <= count + CNT_W'(1);
            end
            if (final_point) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          outer <= '0;
          state <= (count == '0) ? S_FINISH : S_FETCH;
        end
        S_FETCH: state <= S_LATCH;
        S_LATCH: begin
          inner <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          inner <= inner + IDX_W'(1);
          if (last_inner) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!stat.pipe_busy) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (advance) begin
            if (last_outer) begin
              state <= S_FINISH;
            end else begin
              outer <= outer + IDX_W'(1);
              state <= S_FETCH;
            end
          end
        end
        S_FINISH: begin
          if (stat.out_free) begin
            count <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("stored point count beyond capacity");

  a_decide_after_drain: assert property (@(posedge clk) disable iff (rst)
    (cmd.set_pending || cmd.push_pending) |-> !stat.pipe_busy)
    else $error("verdict taken while distance pipeline still busy");

  a_finish_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (count == '0) && !in_stall)
    else $error("run end did not empty the point store");

endmodule

FILE: src/cnsf_datapath.sv
// Datapath: point store, distance pipeline, neighbour box, pending and output registers.
module cnsf_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  cnsf_pkg::cnsf_cmd_t           cmd,
  output cnsf_pkg::cnsf_stat_t          stat,
  input  logic [cnsf_pkg::COORD_W-1:0]  point_x,
  input  logic [cnsf_pkg::COORD_W-1:0]  point_y,
  input  logic                          cfg_valid,
  input  logic [cnsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cnsf_pkg::COORD_W-1:0]  cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cnsf_pkg::COORD_W-1:0]  kept_x,
  output logic [cnsf_pkg::COORD_W-1:0]  kept_y,
  output logic                          end_of_run,
  output logic                          none_kept
);
  import cnsf_pkg::*;

  logic [COORD_W-1:0]   dist_thr;
  logic [NBR_W-1:0]     min_nbr;
  logic [COORD_W-1:0]   spread_x_min;
  logic [COORD_W-1:0]   spread_y_min;
  logic [SQ_W-1:0]      th_sq;

  logic [2*COORD_W-1:0] rdata;
  logic [COORD_W-1:0]   rx;
  logic [COORD_W-1:0]   ry;
  logic [COORD_W-1:0]   ox;
  logic [COORD_W-1:0]   oy;

  logic                 v0;
  logic                 v1;
  logic                 v2;
  logic [COORD_W-1:0]   dx;
  logic [COORD_W-1:0]   dy;
  logic [COORD_W-1:0]   px1;
  logic [COORD_W-1:0]   py1;
  logic [SQ_W-1:0]      sq_x;
  logic [SQ_W-1:0]      sq_y;
  logic [COORD_W-1:0]   px2;
  logic [COORD_W-1:0]   py2;
  logic [SQ_W:0]        dist_sq;
  logic                 hit;

  logic [CNT_W-1:0]     tally;
  logic [COORD_W-1:0]   box_min_x;
  logic [COORD_W-1:0]   box_max_x;
  logic [COORD_W-1:0]   box_min_y;
  logic [COORD_W-1:0]   box_max_y;

  logic                 pending_valid;
  logic [COORD_W-1:0]   pend_x;
  logic [COORD_W-1:0]   pend_y;
  logic                 out_free;

  cnsf_ram #(
    .WIDTH(2 * COORD_W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (cmd.load_we),
    .waddr(cmd.load_addr),
    .wdata({point_x, point_y}),
    .raddr(cmd.rd_addr),
    .rdata(rdata)
  );

  assign rx = rdata[2*COORD_W-1:COORD_W];
  assign ry = rdata[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_thr     <= DIST_RESET;
      min_nbr      <= NBR_RESET;
      spread_x_min <= SPREAD_RESET;
      spread_y_min <= SPREAD_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DIST:     dist_thr     <= cfg_data;
        CFG_MIN_NBR:  min_nbr      <= cfg_data[NBR_W-1:0];
        CFG_SPREAD_X: spread_x_min <= cfg_data;
        CFG_SPREAD_Y: spread_y_min <= cfg_data;
        default:      dist_thr     <= dist_thr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.th_load) begin
      th_sq <= dist_thr * dist_thr;
    end
    if (cmd.latch_outer) begin
      ox <= rx;
      oy <= ry;
    end
    dx   <= (ox >= rx) ? ox - rx : rx - ox;
    dy   <= (oy >= ry) ? oy - ry : ry - oy;
    px1  <= rx;
    py1  <= ry;
    sq_x <= dx * dx;
    sq_y <= dy * dy;
    px2  <= px1;
    py2  <= py1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= cmd.scan_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign hit     = v2 && (dist_sq < {1'b0, th_sq});

  always_ff @(posedge clk) begin
    if (rst) begin
      tally     <= '0;
      box_min_x <= '0;
      box_max_x <= '0;
      box_min_y <= '0;
      box_max_y <= '0;
    end else if (cmd.latch_outer) begin
      tally     <= '0;
      box_min_x <= '0;
      box_max_x <= '0;
      box_min_y <= '0;
      box_max_y <= '0;
    end else if (hit) begin
      tally <= tally + CNT_W'(1);
      if (tally == '0) begin
        box_min_x <= px2;
        box_max_x <= px2;
        box_min_y <= py2;
        box_max_y <= py2;
      end else begin
        if (px2 < box_min_x) box_min_x <= px2;
        if (px2 > box_max_x) box_max_x <= px2;
        if (py2 < box_min_y) box_min_y <= py2;
        if (py2 > box_max_y) box_max_y <= py2;
      end
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.set_pending) begin
        pending_valid <= 1'b1;
      end else if (cmd.finish) begin
        pending_valid <= 1'b0;
      end
      if (cmd.push_pending || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_pending) begin
      pend_x <= ox;
      pend_y <= oy;
    end
    if (cmd.push_pending) begin
      kept_x     <= pend_x;
      kept_y     <= pend_y;
      end_of_run <= 1'b0;
      none_kept  <= 1'b0;
    end else if (cmd.finish) begin
      kept_x     <= pending_valid ? pend_x : '0;
      kept_y     <= pending_valid ? pend_y : '0;
      end_of_run <= 1'b1;
      none_kept  <= !pending_valid;
    end
  end

  always_comb begin
    stat.pipe_busy     = v0 || v1 || v2;
    stat.out_free      = out_free;
    stat.pending_valid = pending_valid;
    stat.kept          = (tally >= CNT_W'(min_nbr)) &&
                         ((box_max_x - box_min_x) >= spread_x_min) &&
                         ((box_max_y - box_min_y) >= spread_y_min);
  end

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    (tally != '0) |-> (box_min_x <= box_max_x) && (box_min_y <= box_max_y))
    else $error("neighbour box corners out of order");

  a_tally_bounded: assert property (@(posedge clk) disable iff (rst)
    tally < CNT_W'(MAX_POINTS))
    else $error("neighbour tally beyond stored points");

  a_finish_marks_end: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid && end_of_run && !pending_valid)
    else $error("run end not marked on the output");

endmodule

FILE: src/corner_neighbor_spread_filter_top.sv
// Top level of the corner neighbour spread filter: controller, datapath and ports.
//
// Corners arrive one per input transfer as unsigned 12.4 coordinates and are
// written into a 64-entry point store at one per cycle; points past capacity
// are dropped. The transfer carrying final_point closes the set (it is stored
// too if there is room) and starts a filtering run, during which in_stall
// stays high. For each stored point the run streams every stored point out of
// the store's single read port, one per cycle, through a four-stage pipeline
// (read, absolute difference, squaring, compare and box update). Kept corners
// leave in load order through an output register; each is held back one slot
// so that the last can carry end_of_run, and a run with no survivors yields
// one result with none_kept and end_of_run set and zero coordinates. A stalled
// output holds the run until the result is taken. Configuration writes are
// always accepted (cfg_ready is tied high) and should be made between runs.
module corner_neighbor_spread_filter_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cnsf_pkg::COORD_W-1:0]   point_x,
  input  logic [cnsf_pkg::COORD_W-1:0]   point_y,
  input  logic                           final_point,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cnsf_pkg::COORD_W-1:0]   kept_x,
  output logic [cnsf_pkg::COORD_W-1:0]   kept_y,
  output logic                           end_of_run,
  output logic                           none_kept,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cnsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cnsf_pkg::COORD_W-1:0]   cfg_data
);
  import cnsf_pkg::*;

  cnsf_cmd_t  cmd;
  cnsf_stat_t stat;

  // Registers take a write in any cycle; the contract keeps writes between runs.
  assign cfg_ready = 1'b1;

  // Sequence loading, the all-pairs scan and result release.
  cnsf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .final_point(final_point),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Hold the points, measure distances, grow the neighbour box, drive results.
  cnsf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .point_x   (point_x),
    .point_y   (point_y),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kept_x    (kept_x),
    .kept_y    (kept_y),
    .end_of_run(end_of_run),
    .none_kept (none_kept)
  );

endmodule

FILE: test/tb_corner_neighbor_spread_filter_top.sv
// Self-checking testbench for the corner neighbour spread filter top level.
module tb_corner_neighbor_spread_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cnsf_pkg::*;

  // Several register settings, each followed by a batch of corner sets.
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 14;
  // Quiet cycles after the last result before registers are touched or the
  // verdict is given; the output register and the run controller settle well
  // within this.
  localparam int SETTLE_CYCLES  = 16;
  // Filtering a full store can leave every port quiet for the whole run; the
  // limit allows well beyond that before declaring the block stuck.
  localparam int WATCHDOG_LIMIT = 25000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
    logic               calm;
  } corner_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               end_run;
    logic               empty;
  } survivor_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [COORD_W-1:0]   point_x     = '0;
  logic [COORD_W-1:0]   point_y     = '0;
  logic                 final_point = 1'b0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [COORD_W-1:0]   kept_x;
  logic [COORD_W-1:0]   kept_y;
  logic                 end_of_run;
  logic                 none_kept;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_DIST;
  logic [COORD_W-1:0]   cfg_data    = '0;

  // Predictor's copy of the registers, tracking every accepted write.
  logic [COORD_W-1:0]   radius       = DIST_RESET;
  logic [NBR_W-1:0]     need_nbrs    = NBR_RESET;
  logic [COORD_W-1:0]   spread_x_min = SPREAD_RESET;
  logic [COORD_W-1:0]   spread_y_min = SPREAD_RESET;

  // Predictor's copy of the point store.
  logic [COORD_W-1:0]   corner_x [MAX_POINTS];
  logic [COORD_W-1:0]   corner_y [MAX_POINTS];
  int unsigned          corner_count = 0;

  corner_t              corner_feed[$];     // corners waiting to be driven
  survivor_t            survivor_queue[$];  // results still owed by the block
  int unsigned          corners_queued = 0;
  int unsigned          corners_taken  = 0;
  int unsigned          mismatch_count = 0;
  int unsigned          idle_cycles    = 0;
  bit                   steady         = 1'b0;  // no idling on either side

  corner_neighbor_spread_filter_top DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .final_point (final_point),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kept_x      (kept_x),
    .kept_y      (kept_y),
    .end_of_run  (end_of_run),
    .none_kept   (none_kept),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // Idle cycles before the next transfer; none at all while a calm set runs.
  function automatic int unsigned pause_length();
    return steady ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return COORD_W'(v);
  endfunction

  // Decide whether stored corner i survives: count the other corners strictly
  // inside the radius, grow their bounding box, then test count and extents.
  function automatic bit corner_survives(int unsigned i);
    longint unsigned reach2, dx, dy;
    int unsigned     tally;
    logic [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
    reach2 = 64'(radius) * 64'(radius);
    tally  = 0;
    lo_x = '0; hi_x = '0; lo_y = '0; hi_y = '0;
    for (int unsigned j = 0; j < corner_count; j++) begin
      if (j != i) begin
        dx = (corner_x[i] >= corner_x[j]) ? 64'(corner_x[i] - corner_x[j])
                                          : 64'(corner_x[j] - corner_x[i]);
        dy = (corner_y[i] >= corner_y[j]) ? 64'(corner_y[i] - corner_y[j])
                                          : 64'(corner_y[j] - corner_y[i]);
        if (dx * dx + dy * dy < reach2) begin
          if (tally == 0) begin
            lo_x = corner_x[j]; hi_x = corner_x[j];
            lo_y = corner_y[j]; hi_y = corner_y[j];
          end else begin
            if (corner_x[j] < lo_x) lo_x = corner_x[j];
            if (corner_x[j] > hi_x) hi_x = corner_x[j];
            if (corner_y[j] < lo_y) lo_y = corner_y[j];
            if (corner_y[j] > hi_y) hi_y = corner_y[j];
          end
          tally++;
        end
      end
    end
    // With no neighbours the box is empty and both extents read as zero.
    if (tally < need_nbrs) return 1'b0;
    return (hi_x - lo_x) >= spread_x_min && (hi_y - lo_y) >= spread_y_min;
  endfunction

  // Work out the results of a completed set, in load order, then empty the store.
  task automatic run_spread_filter();
    survivor_t s;
    int unsigned kept_n;
    kept_n = 0;
    for (int unsigned i = 0; i < corner_count; i++) begin
      if (corner_survives(i)) begin
        s = '{corner_x[i], corner_y[i], 1'b0, 1'b0};
        survivor_queue = {survivor_queue, s};
        kept_n++;
      end
    end
    if (kept_n == 0) begin
      // nothing survived: a single empty marker closes the run
      s = '{'0, '0, 1'b1, 1'b1};
      survivor_queue = {survivor_queue, s};
    end else begin
      s = survivor_queue.pop_back();
      s.end_run = 1'b1;
      survivor_queue = {survivor_queue, s};
    end
    corner_count = 0;
  endtask

  // Account for one accepted corner: store it if there is room, and filter
  // on the final one even when the corner itself is dropped.
  task automatic absorb_corner(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
    corners_taken++;
    if (corner_count < MAX_POINTS) begin
      corner_x[corner_count] = x;
      corner_y[corner_count] = y;
      corner_count++;
    end
    if (last) run_spread_filter();
  endtask

  task automatic queue_corner(int unsigned x, int unsigned y, bit last, bit calm);
    corner_t c;
    c = '{COORD_W'(x), COORD_W'(y), last, calm};
    corner_feed = {corner_feed, c};
    corners_queued++;
  endtask

  // Queue one set of set_len corners, the last one marked. Most sets gather
  // round a centre at the current radius so that neighbours are common; the
  // rest scatter over the whole plane.
  task automatic queue_corner_set(int unsigned set_len);
    bit clustered, calm;
    int cx, cy, reach, px, py;
    clustered = ($urandom_range(0, 9) < 7);
    calm      = ($urandom_range(0, 3) == 0);
    cx        = $urandom_range(0, 65535);
    cy        = $urandom_range(0, 65535);
    reach     = (radius == 0) ? 16 : ((radius > 16384) ? 16384 : int'(radius));
    px = cx;
    py = cy;
    for (int unsigned k = 0; k < set_len; k++) begin
      if (!clustered) begin
        px = $urandom_range(0, 65535);
        py = $urandom_range(0, 65535);
      end else if (k != 0 && $urandom_range(0, 9) == 0) begin
        // step exactly one radius along x: on the boundary, so not a neighbour
        px = px + int'(radius);
      end else begin
        px = cx + int'($urandom_range(0, 2 * reach)) - reach;
        py = cy + int'($urandom_range(0, 2 * reach)) - reach;
      end
      px = clamp_coord(px);
      py = clamp_coord(py);
      queue_corner(px, py, k == set_len - 1, calm);
    end
  endtask

  // Wait until every queued corner has been taken and every result seen, then
  // wait out the quiet settle period so the block can finish.
  task automatic drain_and_settle();
    while (corners_taken != corners_queued || survivor_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_t reg_code, logic [COORD_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= reg_code;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    // the write took effect at this edge; mirror it
    case (reg_code)
      CFG_DIST:     radius       = value;
      CFG_MIN_NBR:  need_nbrs    = value[NBR_W-1:0];
      CFG_SPREAD_X: spread_x_min = value;
      CFG_SPREAD_Y: spread_y_min = value;
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned radius_val, int unsigned nbrs, int unsigned sx,
                           int unsigned sy);
    write_register(CFG_DIST, COORD_W'(radius_val));
    write_register(CFG_MIN_NBR, COORD_W'(nbrs));
    write_register(CFG_SPREAD_X, COORD_W'(sx));
    write_register(CFG_SPREAD_Y, COORD_W'(sy));
  endtask

  function automatic void check_field(string name, logic [COORD_W-1:0] want,
                                      logic [COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Input side: present queued corners, hold each one while stalled, and feed
  // every accepted transfer to the predictor.
  always @(posedge clk) begin : feed_side
    corner_t item;
    int unsigned feed_wait;
    if (rst) begin
      in_valid  <= 1'b0;
      feed_wait = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) absorb_corner(point_x, point_y, final_point);
      if (feed_wait == 0 && corner_feed.size() != 0) begin
        item = corner_feed.pop_front();
        steady = item.calm;
        in_valid    <= 1'b1;
        point_x     <= item.x;
        point_y     <= item.y;
        final_point <= item.last;
        feed_wait = pause_length();
      end else begin
        in_valid <= 1'b0;
        if (feed_wait != 0) feed_wait--;
      end
    end
  end

  // Output side: stall for a drawn number of cycles before each transfer and
  // compare every accepted result with the oldest one owed.
  always @(posedge clk) begin : drain_side
    survivor_t want;
    int unsigned hold_left;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (survivor_queue.size() == 0) begin
          $error("result with nothing owed: kept_x %0d kept_y %0d end_of_run %0b none_kept %0b",
                 kept_x, kept_y, end_of_run, none_kept);
          mismatch_count++;
        end else begin
          want = survivor_queue.pop_front();
          check_field("kept_x", want.x, kept_x);
          check_field("kept_y", want.y, kept_y);
          check_field("end_of_run", COORD_W'(want.end_run), COORD_W'(end_of_run));
          check_field("none_kept", COORD_W'(want.empty), COORD_W'(none_kept));
        end
        hold_left = pause_length();
      end else if (out_valid && hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0);
    end
  end

  // Watchdog: give up when no port has moved a transfer for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase_items, set_len, pick, radius_pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      // registers change only with the block idle and nothing owed
      if (p > 0) begin
        drain_and_settle();
        case (p)
          1: write_all(2880, 0, 0, 0);              // no neighbours needed
          2: write_all(0, 0, 0, 0);                 // zero radius: nobody has neighbours
          3: write_all(65535, 63, 65535, 65535);    // every register at its top
          4: write_all(65535, 1, 0, 0);             // huge radius, nearly all kept
          default: begin
            radius_pick = $urandom_range(32, 6000);
            write_all(radius_pick,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 6),
                      $urandom_range(0, radius_pick), $urandom_range(0, radius_pick));
          end
        endcase
      end
      phase_items = 0;

      if (p == 0) begin
        // a far outlier, a square of corners round a centre, and one corner
        // exactly one radius from the centre; the centre closes the set
        queue_corner(40000, 40000, 0, 1);
        queue_corner(15040, 15040, 0, 1);
        queue_corner(16960, 15040, 0, 1);
        queue_corner(15040, 16960, 0, 1);
        queue_corner(16960, 16960, 0, 1);
        queue_corner(18880, 16000, 0, 1);
        queue_corner(16000, 16000, 1, 1);
        // lone corners and opposite extremes: nothing survives
        queue_corner(0, 0, 1, 0);
        queue_corner(0, 65535, 0, 0);
        queue_corner(65535, 0, 1, 0);
        queue_corner(65535, 65535, 1, 0);
      end
      if (p == 1) begin
        // a lone corner survives once no neighbours and no spread are needed
        queue_corner(12345, 54321, 1, 0);
      end
      if (p == 0 || p == 4) begin
        // overfill the store so the final corner itself is dropped
        set_len = 65 + $urandom_range(0, 5);
        queue_corner_set(set_len);
        phase_items += set_len;
      end

      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)      set_len = $urandom_range(1, 8);
        else if (pick < 92) set_len = $urandom_range(9, 24);
        else                set_len = $urandom_range(25, 64);
        queue_corner_set(set_len);
        phase_items += set_len;
      end
    end

    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
